// ===== hw/rtl/tnsti_pkg.sv =====
// Package for the top-N score table insert unit: sizes, reset table and control types.
`timescale 1ns / 1ps
`default_nettype none

package tnsti_pkg;

  // Table geometry and field widths.
  localparam int unsigned Entries = 8;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned ScoreW  = 32;
  localparam int unsigned TagW    = 16;
  localparam int unsigned RankW   = 6;

  // Constants of the reset table: entry f holds ResetBase + f*f*ResetStep.
  localparam int unsigned ResetBase = 20;
  localparam int unsigned ResetStep = 300;

  typedef logic [ScoreW-1:0] score_t;
  typedef logic [TagW-1:0]   tag_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [RankW-1:0]  rank_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the incoming item and restart the scan
    logic reject;      // item is not placed, result is zero
    logic shift;       // move the entry above the scan position down one place
    logic place;       // write the candidate at the scan position
    logic emit;        // copy the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic qualifies;     // candidate is nonzero and above the smallest entry
    logic next_smaller;  // the entry one place above the scan position is below the candidate
  } status_t;

  // Reset score of entry f.
  function automatic score_t reset_score(input int unsigned f);
    reset_score = ScoreW'(ResetBase + f * f * ResetStep);
  endfunction

  // Reset tag of entry f.
  function automatic tag_t reset_tag(input int unsigned f);
    reset_tag = TagW'(f);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tnsti_if.sv =====
// Handshake interfaces for the input and result channels of the score table unit.
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one candidate score and its tag per item.
interface tnsti_in_if;
  logic                   valid;
  logic                   ready;
  tnsti_pkg::score_t      new_score;
  tnsti_pkg::tag_t        tag_id;

  modport source (output valid, output new_score, output tag_id, input ready);
  modport sink   (input valid, input new_score, input tag_id, output ready);
endinterface

// Result channel: placement flag and final rank per item.
interface tnsti_out_if;
  logic                   valid;
  logic                   ready;
  logic                   placed;
  tnsti_pkg::rank_t       rank_index;

  modport source (output valid, output placed, output rank_index, input ready);
  modport sink   (input valid, input placed, input rank_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tnsti_dp.sv =====
// Datapath of the score table unit: the sorted table, the scan position and the result registers.
`timescale 1ns / 1ps
`default_nettype none

module tnsti_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tnsti_pkg::score_t   new_score_i,
  input  wire tnsti_pkg::tag_t     tag_id_i,
  input  wire tnsti_pkg::cmd_t     cmd_i,
  output tnsti_pkg::status_t       status_o,
  output logic                     placed_o,
  output tnsti_pkg::rank_t         rank_index_o
);

  tnsti_pkg::score_t score_q [tnsti_pkg::Entries];
  tnsti_pkg::tag_t   tag_q   [tnsti_pkg::Entries];

  tnsti_pkg::score_t cand_q;
  tnsti_pkg::tag_t   cand_tag_q;
  tnsti_pkg::idx_t   pos_q;
  logic              res_placed_q;
  tnsti_pkg::rank_t  res_rank_q;
  logic              out_placed_q;
  tnsti_pkg::rank_t  out_rank_q;

  tnsti_pkg::idx_t   pos_inc;
  logic              pos_last;

  // Scan position one place up; only used while the position is not the top entry.
  assign pos_inc  = pos_q + tnsti_pkg::idx_t'(1);
  assign pos_last = (pos_q == tnsti_pkg::idx_t'(tnsti_pkg::Entries - 1));

  // Status towards the controller.
  assign status_o.qualifies    = (cand_q != '0) && (cand_q > score_q[0]);
  assign status_o.next_smaller = !pos_last && (score_q[pos_inc] < cand_q);

  // Table: reset loads the ascending start table, shift moves one entry, place writes cand_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned f = 0; f < tnsti_pkg::Entries; f++) begin
        score_q[f] <= tnsti_pkg::reset_score(f);
        tag_q[f]   <= tnsti_pkg::reset_tag(f);
      end
    end else if (cmd_i.shift) begin
      score_q[pos_q] <= score_q[pos_inc];
      tag_q[pos_q]   <= tag_q[pos_inc];
    end else if (cmd_i.place) begin
      score_q[pos_q] <= cand_q;
      tag_q[pos_q]   <= cand_tag_q;
    end
  end

  // Candidate capture, scan position and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cand_q     <= new_score_i;
      cand_tag_q <= tag_id_i;
      pos_q      <= '0;
    end else if (cmd_i.shift) begin
      pos_q <= pos_inc;
    end
    if (cmd_i.reject) begin
      res_placed_q <= 1'b0;
      res_rank_q   <= '0;
    end else if (cmd_i.place) begin
      res_placed_q <= 1'b1;
      res_rank_q   <= tnsti_pkg::rank_t'(pos_q);
    end
    if (cmd_i.emit) begin
      out_placed_q <= res_placed_q;
      out_rank_q   <= res_rank_q;
    end
  end

  assign placed_o     = out_placed_q;
  assign rank_index_o = out_rank_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tnsti_ctrl.sv =====
// Controller of the score table unit: sequences the check, the upward scan and the result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module tnsti_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire tnsti_pkg::status_t  status_i,
  output tnsti_pkg::cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // The output register can take a result when empty or when its item leaves now.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Commands decoded from the state and the datapath status.
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.reject = (state_q == S_CHECK) && !status_i.qualifies;
    cmd_o.shift  = (state_q == S_SCAN) && status_i.next_smaller;
    cmd_o.place  = (state_q == S_SCAN) && !status_i.next_smaller;
    cmd_o.emit   = (state_q == S_EMIT) && out_free;
  end

  // State and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          state_q <= status_i.qualifies ? S_SCAN : S_EMIT;
        end
        S_SCAN: begin
          if (!status_i.next_smaller) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/top_n_score_table_insert_unit.sv =====
// Top level of the top-N score table insert unit.
//
// The unit keeps a table of tnsti_pkg::Entries scores with tags, sorted ascending.
// Each item on in_i offers a score and a tag. A nonzero score strictly above the
// smallest entry drops that entry and moves up past every strictly smaller entry;
// equal entries stay above it. One result leaves on out_o for every item: placed
// and the final rank (zero when not placed).
// Steps: the item is taken in S_IDLE and checked against entry 0 in S_CHECK; then in
// S_SCAN the scan moves up one entry per cycle, shifting each smaller entry down
// and then writing the candidate, and S_EMIT loads the output register once it
// is free. One item is in work at a time; in_i is ready again once its result
// is in the output register. A result waiting on a stalled receiver does not
// block the next item, which is worked on and then held until the output
// register frees.
// Reset (rst_ni low, asynchronous) empties the output register and loads the
// table with score 20+f*f*300 and tag f in entry f.
`timescale 1ns / 1ps
`default_nettype none

module top_n_score_table_insert_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tnsti_in_if.sink    in_i,
  tnsti_out_if.source out_o
);

  tnsti_pkg::cmd_t    cmd;
  tnsti_pkg::status_t status;

  tnsti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tnsti_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .new_score_i  (in_i.new_score),
    .tag_id_i     (in_i.tag_id),
    .cmd_i        (cmd),
    .status_o     (status),
    .placed_o     (out_o.placed),
    .rank_index_o (out_o.rank_index)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tnsti_checker.sv =====
// Port-level checker for the score table unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tnsti_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic              out_placed_i,
  input wire tnsti_pkg::rank_t  out_rank_i
);

  // A rejected item always reports rank zero.
  a_reject_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_placed_i |-> out_rank_i == '0)
    else $error("rejected item with nonzero rank");

  // A placed item lands inside the table.
  a_rank_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_placed_i
      |-> out_rank_i <= tnsti_pkg::rank_t'(tnsti_pkg::Entries - 1))
    else $error("rank beyond the table");

  // Only one item is in work: after an accept the input is not ready.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in work");

  // A stalled result stays and holds its value.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i
      |=> out_valid_i && $stable(out_placed_i) && $stable(out_rank_i))
    else $error("stalled result changed");

endmodule

bind top_n_score_table_insert_unit tnsti_checker u_tnsti_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_placed_i (out_o.placed),
  .out_rank_i   (out_o.rank_index)
);

`default_nettype wire

// ===== tb/tb_top_n_score_table_insert_unit.sv =====
// Self-checking testbench for the top-N score table insert unit.
`timescale 1ns / 1ps

module tb_top_n_score_table_insert_unit;

  // Cycles in which neither channel moves an item before the run is declared hung.
  localparam int unsigned StallLimit = 1000;
  // Cycles allowed after the last result for a stray extra result to show.
  localparam int unsigned DrainCycles = tnsti_pkg::Entries + 12;
  localparam int unsigned RandomItems = 500;

  typedef struct {
    logic              placed;
    tnsti_pkg::rank_t  rank_index;
  } rank_result_t;

  logic clk_i;
  logic rst_ni;

  tnsti_in_if  in_ch ();
  tnsti_out_if out_ch ();

  top_n_score_table_insert_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Predicted contents of the score table, ascending from index 0.
  tnsti_pkg::score_t score_tab [tnsti_pkg::Entries];
  tnsti_pkg::tag_t   tag_tab   [tnsti_pkg::Entries];

  rank_result_t pending_ranks[$];
  rank_result_t oldest;
  int unsigned  errors;
  int unsigned  idle_cycles;
  int unsigned  stall_left;
  bit           steady_in;
  bit           steady_out;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out the outcome of one candidate and update the predicted table.
  function automatic rank_result_t rank_after_insert(input tnsti_pkg::score_t cand,
                                                     input tnsti_pkg::tag_t tag);
    rank_result_t res;
    int unsigned  pos;
    res.placed     = 1'b0;
    res.rank_index = '0;
    if (cand != '0 && cand > score_tab[0]) begin
      pos = 0;
      while (pos + 1 < tnsti_pkg::Entries && score_tab[pos+1] < cand) begin
        score_tab[pos] = score_tab[pos+1];
        tag_tab[pos]   = tag_tab[pos+1];
        pos++;
      end
      score_tab[pos] = cand;
      tag_tab[pos]   = tag;
      res.placed     = 1'b1;
      res.rank_index = tnsti_pkg::rank_t'(pos);
    end
    return res;
  endfunction

  // Offer one item after a random gap and record its expected result once taken.
  task automatic send_item(input tnsti_pkg::score_t cand, input tnsti_pkg::tag_t tag);
    int unsigned gap;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_in || roll < 60) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 98) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.new_score <= cand;
    in_ch.tag_id    <= tag;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_ranks.push_back(rank_after_insert(cand, tag));
  endtask

  // Withdraw the input and wait until every outstanding result has been checked.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_ranks.size() != 0);
  endtask

  // Boundary values, equal scores, rejects and the top slot.
  task automatic test_directed();
    send_item(32'h0000_0000, 16'hFFFF);  // zero is never placed
    send_item(score_tab[0], 16'h0000);   // equal to the smallest entry
    send_item(score_tab[0] - 1, 16'h1234);
    send_item(score_tab[0] + 1, 16'hAAAA);
    send_item(32'hFFFF_FFFF, 16'hFFFF);  // lands at the top
    send_item(32'hFFFF_FFFF, 16'h5555);  // settles below its equal
    send_item(score_tab[3], 16'h0001);   // equal to a middle entry
    send_item(score_tab[tnsti_pkg::Entries/2] + 1, 16'h8000);
    send_item(32'h8000_0000, 16'h7FFF);
    send_item(32'h0000_0001, 16'h00FF);
    send_item(32'h5555_5555, 16'hFF00);
    send_item(32'hAAAA_AAAA, 16'h0F0F);
    send_item(score_tab[1], 16'hF0F0);   // ties with the new second entry
    send_item(score_tab[0] + 1, 16'h3C3C);
  endtask

  // The sender holds off until the unit has drained, then sends back to back.
  task automatic test_drain_pause();
    wait_for_results();
    steady_in = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_item(score_tab[$urandom_range(0, tnsti_pkg::Entries-1)] + $urandom_range(0, 3),
                tnsti_pkg::tag_t'($urandom_range(0, 65535)));
    end
    steady_in = 1'b0;
    wait_for_results();
  endtask

  // Mostly candidates near the current table contents, with noise mixed in.
  task automatic test_random_inserts();
    tnsti_pkg::score_t cand;
    int unsigned       idx;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 50 == 0) steady_in = ($urandom_range(0, 3) == 0);
      idx = $urandom_range(0, tnsti_pkg::Entries-1);
      case ($urandom_range(0, 9))
        0: cand = '0;
        1: cand = $urandom_range(0, score_tab[0]);
        2, 3: cand = $urandom();
        4: cand = score_tab[idx];
        5: cand = 32'hFFFF_FFFF;
        6: begin
          if (idx < tnsti_pkg::Entries-1 && score_tab[idx] < score_tab[idx+1]) begin
            cand = $urandom_range(score_tab[idx], score_tab[idx+1]);
          end else begin
            cand = score_tab[idx] + 1;
          end
        end
        default: cand = score_tab[idx] + $urandom_range(0, 4) - 2;
      endcase
      send_item(cand, tnsti_pkg::tag_t'($urandom_range(0, 65535)));
    end
    steady_in = 1'b0;
  endtask

  // Result side: random stalls, some long, with runs of steady acceptance.
  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    steady_out = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) steady_out = !steady_out;
        if (!steady_out && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 2);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_ranks.size() == 0) begin
        $error("unexpected result: placed=%0b rank_index=%0d",
               out_ch.placed, out_ch.rank_index);
        errors++;
      end else begin
        oldest = pending_ranks.pop_front();
        if (out_ch.placed !== oldest.placed) begin
          $error("placed: expected %0b, got %0b", oldest.placed, out_ch.placed);
          errors++;
        end
        if (out_ch.rank_index !== oldest.rank_index) begin
          $error("rank_index: expected %0d, got %0d", oldest.rank_index, out_ch.rank_index);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("[top_n_score_table_insert_unit] ERROR");
        $finish;
      end
    end
  end

  // Reset, the test sequence and the final verdict.
  initial begin
    errors      = 0;
    idle_cycles = 0;
    steady_in   = 1'b0;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.new_score <= '0;
    in_ch.tag_id    <= '0;
    for (int f = 0; f < tnsti_pkg::Entries; f++) begin
      score_tab[f] = tnsti_pkg::score_t'(tnsti_pkg::ResetBase + f * f * tnsti_pkg::ResetStep);
      tag_tab[f]   = tnsti_pkg::tag_t'(f);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_drain_pause();
    test_random_inserts();

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_ranks.size() != 0) begin
      $error("%0d results never arrived", pending_ranks.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[top_n_score_table_insert_unit] OK");
    end else begin
      $display("[top_n_score_table_insert_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tnsti_pkg.sv
hw/rtl/tnsti_if.sv
hw/rtl/tnsti_dp.sv
hw/rtl/tnsti_ctrl.sv
hw/rtl/top_n_score_table_insert_unit.sv
hw/rtl/tnsti_checker.sv
tb/tb_top_n_score_table_insert_unit.sv
